// ===== rtl/core/btb2l_pkg.sv =====
// Shared types and constants of the two-level branch predictor BTB.
// No dependencies; the interfaces, the core and the testbench import this package.
package btb2l_pkg;

   localparam int PC_W       = 32;
   localparam int TAG_W      = 30;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int SHARE_LO   = 2;
   localparam int SHARE_HI   = 16;

   localparam logic [2:0]      MAX_LOG2_ENTRIES = 3'd5;
   localparam logic [4:0]      MAX_TAG_BITS     = 5'd30;
   localparam logic [PC_W-1:0] PC_STEP          = 32'd4;
   localparam logic [1:0]      CTR_RESET        = 2'd1;
   localparam logic [1:0]      CTR_MAX          = 2'd3;
   localparam logic [1:0]      CTR_MIN          = 2'd0;
   localparam logic [1:0]      CTR_TAKEN_MIN    = 2'd2;

   // reset values of the configuration registers
   localparam logic [2:0] RST_LOG2_ENTRIES = 3'd5;
   localparam logic [3:0] RST_HISTORY_BITS = 4'd8;
   localparam logic [4:0] RST_TAG_BITS     = 5'd16;
   localparam logic [1:0] RST_INIT_CTR     = 2'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOG2_ENTRIES   = 3'd0,
      CSR_HISTORY_BITS   = 3'd1,
      CSR_TAG_BITS       = 3'd2,
      CSR_INIT_COUNTER   = 3'd3,
      CSR_GLOBAL_HISTORY = 3'd4,
      CSR_GLOBAL_TABLE   = 3'd5,
      CSR_SHARE_MODE     = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      SHARE_NONE   = 2'd0,
      SHARE_XOR_LO = 2'd1,
      SHARE_XOR_HI = 2'd2
   } share_mode_type;

   typedef enum logic {
      OP_PREDICT = 1'b0,
      OP_UPDATE  = 1'b1
   } opcode_type;

endpackage

// ===== rtl/core/btb2l_if.sv =====
// Handshake channels of the predictor: request, response and CSR write.
// Depends on btb2l_pkg for field widths.
interface btb2l_req_if
   import btb2l_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic            opcode;
   logic [PC_W-1:0] pc;
   logic [PC_W-1:0] actual_target;
   logic            was_taken;
   logic [PC_W-1:0] earlier_prediction;

   modport source (output valid, opcode, pc, actual_target, was_taken, earlier_prediction,
                   input ready);
   modport sink   (input valid, opcode, pc, actual_target, was_taken, earlier_prediction,
                   output ready);
endinterface

interface btb2l_rsp_if
   import btb2l_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic            predict_taken;
   logic [PC_W-1:0] predicted_target;
   logic [PC_W-1:0] flush_count;
   logic [PC_W-1:0] branch_count;

   modport source (output valid, predict_taken, predicted_target, flush_count, branch_count,
                   input ready);
   modport sink   (input valid, predict_taken, predicted_target, flush_count, branch_count,
                   output ready);
endinterface

interface btb2l_csr_if
   import btb2l_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/btb_two_level_branch_predictor_core.sv =====
// Direct-mapped BTB with a two-level adaptive direction predictor.
// Depends on btb2l_pkg, the btb2l channel interfaces and btb2l_ram.
//
// An item passes through a lookup state and a count state, and the next item can
// be taken in the count state of the last one: lookup checks the entry RAM word
// (tag, target, local history), count reads the counter RAM row chosen by the
// entry and then writes the stepped counter back while the next item reads its
// entry. Results enter the response register when the count state ends and wait
// there while the next item is in progress. Counter rows (one per entry plus one
// shared row) and entries have valid flags in flip-flops cleared by reset,
// so no clearing pass is needed and the block takes items right after reset.
// Allocation refills a whole counter row in one write. Configuration writes
// are taken every cycle and must only occur while the block is idle.
module btb_two_level_branch_predictor_core
   import btb2l_pkg::*;
#(
   parameter int MAX_ENTRIES = 32,
   parameter int MAX_HISTORY = 8
) (
   input  logic        clock,
   input  logic        reset,
   btb2l_req_if.sink   req_bus,
   btb2l_rsp_if.source rsp_bus,
   btb2l_csr_if.sink   csr_bus
);

   localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ROWS     = MAX_ENTRIES + 1;
   localparam int CROW_W   = $clog2(ROWS);
   localparam int HIST_W   = MAX_HISTORY;
   localparam int CTRS     = 1 << MAX_HISTORY;
   localparam int ROW_W    = 2 * CTRS;
   localparam int ENT_W    = TAG_W + PC_W + HIST_W;
   localparam logic [CROW_W-1:0] SHARED_ROW = CROW_W'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_COUNT  = 2'd2
   } state_type;

   // configuration
   logic [2:0] log2_entries_ff;
   logic [3:0] history_bits_ff;
   logic [4:0] tag_bits_ff;
   logic [1:0] init_ctr_ff;
   logic       global_hist_ff;
   logic       global_table_ff;
   logic [1:0] share_mode_ff;

   state_type state_ff, state_in;

   // item held across its lookup and count states
   logic              op_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [PC_W-1:0]   tgt_ff;
   logic              taken_ff;
   logic [PC_W-1:0]   earlier_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [TAG_W-1:0]  tag_ff;

   // carried from lookup to count
   logic              hit_ff;
   logic              alloc_local_ff;
   logic [HIST_W-1:0] pos_ff;
   logic [CROW_W-1:0] row_ff;
   logic [PC_W-1:0]   ent_target_ff;

   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [ROWS-1:0]        row_valid_ff;
   logic [HIST_W-1:0]      shared_hist_ff;
   logic [PC_W-1:0]        flush_cnt_ff;
   logic [PC_W-1:0]        branch_cnt_ff;

   logic            rsp_valid_ff;
   logic            rsp_taken_ff;
   logic [PC_W-1:0] rsp_target_ff;
   logic [PC_W-1:0] rsp_flush_ff;
   logic [PC_W-1:0] rsp_branch_ff;

   logic can_finish;
   logic req_ready;
   logic accept;

   // request decode
   logic [2:0]       le_clamp;
   logic [4:0]       tb_clamp;
   logic [4:0]       idx_raw;
   logic [IDX_W-1:0] idx_mod [32];
   logic [IDX_W-1:0] req_idx;
   logic [PC_W-1:0]  tag_shift;
   logic [PC_W-1:0]  tag_mask;
   logic [TAG_W-1:0] req_tag;

   // entry RAM
   logic [ENT_W-1:0] ent_rdata;
   logic [ENT_W-1:0] ent_wdata;
   logic             ent_wr;
   logic [TAG_W-1:0] ent_tag;
   logic [PC_W-1:0]  ent_target;
   logic [HIST_W-1:0] ent_hist;

   // lookup cycle
   logic [3:0]        hl;
   logic [HIST_W-1:0] hmask;
   logic              hit;
   logic              alloc;
   logic [HIST_W-1:0] local_hist;
   logic [HIST_W-1:0] hist_sel;
   logic [HIST_W-1:0] hist_next;
   logic [HIST_W-1:0] pos;
   logic [CROW_W-1:0] row;
   logic              mispredict;

   // counter RAM
   logic              ctr_rd;
   logic              ctr_wr;
   logic [CROW_W-1:0] ctr_waddr;
   logic [ROW_W-1:0]  ctr_wdata;
   logic [ROW_W-1:0]  ctr_rdata;
   logic [ROW_W-1:0]  row_base;
   logic [ROW_W-1:0]  row_new;
   logic [1:0]        ctr_cur;
   logic [1:0]        ctr_next;
   logic              pred_taken;

   // index modulo table, resolved at elaboration
   for (genvar g = 0; g < 32; g++) begin : g_idx_mod
      assign idx_mod[g] = IDX_W'(g % MAX_ENTRIES);
   end

   always_comb begin
      le_clamp  = (log2_entries_ff > MAX_LOG2_ENTRIES) ? MAX_LOG2_ENTRIES : log2_entries_ff;
      tb_clamp  = (tag_bits_ff > MAX_TAG_BITS) ? MAX_TAG_BITS : tag_bits_ff;
      idx_raw   = req_bus.pc[2 +: 5] & ((5'd1 << le_clamp) - 5'd1);
      req_idx   = idx_mod[idx_raw];
      tag_shift = req_bus.pc >> (6'd2 + 6'(le_clamp));
      tag_mask  = (32'd1 << tb_clamp) - 32'd1;
      req_tag   = TAG_W'(tag_shift & tag_mask);
   end

   assign can_finish = !rsp_valid_ff || rsp_bus.ready;
   assign req_ready  = (state_ff == ST_IDLE) || (state_ff == ST_COUNT && can_finish);
   assign accept     = req_bus.valid && req_ready;
   assign req_bus.ready = req_ready;
   assign csr_bus.ready = 1'b1;

   btb2l_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr),
      .wr_addr (idx_ff),
      .wr_data (ent_wdata),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (ent_rdata)
   );

   assign ent_tag    = ent_rdata[ENT_W-1 -: TAG_W];
   assign ent_target = ent_rdata[HIST_W +: PC_W];
   assign ent_hist   = ent_rdata[HIST_W-1:0];

   // lookup cycle: hit check, history select, counter position
   always_comb begin
      hl         = (history_bits_ff > 4'(MAX_HISTORY)) ? 4'(MAX_HISTORY) : history_bits_ff;
      hmask      = HIST_W'((9'd1 << hl) - 9'd1);
      hit        = valid_ff[idx_ff] && (ent_tag == tag_ff);
      alloc      = op_ff && !hit;
      local_hist = alloc ? '0 : ent_hist;
      hist_sel   = global_hist_ff ? shared_hist_ff : local_hist;
      case (share_mode_ff)
         SHARE_XOR_LO: pos = hist_sel ^ pc_ff[SHARE_LO +: HIST_W];
         SHARE_XOR_HI: pos = hist_sel ^ pc_ff[SHARE_HI +: HIST_W];
         default:      pos = hist_sel;
      endcase
      pos        = pos & hmask;
      row        = global_table_ff ? SHARED_ROW : CROW_W'(idx_ff);
      hist_next  = HIST_W'({hist_sel, taken_ff}) & hmask;
      ent_wr     = (state_ff == ST_LOOKUP) && op_ff;
      ent_wdata  = {tag_ff, tgt_ff, (global_hist_ff ? local_hist : hist_next)};
      mispredict = taken_ff ? (earlier_ff != tgt_ff) : (earlier_ff != (pc_ff + PC_STEP));
   end

   // count cycle: pick row contents, step the counter
   always_comb begin
      if (alloc_local_ff) begin
         row_base = {CTRS{init_ctr_ff}};
      end else if (row_valid_ff[row_ff]) begin
         row_base = ctr_rdata;
      end else begin
         row_base = {CTRS{CTR_RESET}};
      end
      ctr_cur = row_base[{pos_ff, 1'b0} +: 2];
      if (taken_ff) begin
         ctr_next = (ctr_cur == CTR_MAX) ? ctr_cur : ctr_cur + 2'd1;
      end else begin
         ctr_next = (ctr_cur == CTR_MIN) ? ctr_cur : ctr_cur - 2'd1;
      end
      row_new = row_base;
      row_new[{pos_ff, 1'b0} +: 2] = ctr_next;
      pred_taken = hit_ff && (ctr_cur >= CTR_TAKEN_MIN);
   end

   // row read in lookup, own-row refill on shared alloc, write-back in count
   always_comb begin
      ctr_rd    = (state_ff == ST_LOOKUP);
      ctr_wr    = 1'b0;
      ctr_waddr = row_ff;
      ctr_wdata = row_new;
      if (state_ff == ST_LOOKUP && alloc && global_table_ff) begin
         ctr_wr    = 1'b1;
         ctr_waddr = CROW_W'(idx_ff);
         ctr_wdata = {CTRS{init_ctr_ff}};
      end else if (state_ff == ST_COUNT && can_finish && op_ff) begin
         ctr_wr    = 1'b1;
      end
   end

   btb2l_ram #(
      .WIDTH (ROW_W),
      .DEPTH (ROWS)
   ) u_counter_ram (
      .clock   (clock),
      .wr_en   (ctr_wr),
      .wr_addr (ctr_waddr),
      .wr_data (ctr_wdata),
      .rd_en   (ctr_rd),
      .rd_addr (row),
      .rd_data (ctr_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_entries_ff <= RST_LOG2_ENTRIES;
         history_bits_ff <= RST_HISTORY_BITS;
         tag_bits_ff     <= RST_TAG_BITS;
         init_ctr_ff     <= RST_INIT_CTR;
         global_hist_ff  <= 1'b0;
         global_table_ff <= 1'b0;
         share_mode_ff   <= SHARE_NONE;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_LOG2_ENTRIES:   log2_entries_ff <= csr_bus.data[2:0];
            CSR_HISTORY_BITS:   history_bits_ff <= csr_bus.data[3:0];
            CSR_TAG_BITS:       tag_bits_ff     <= csr_bus.data[4:0];
            CSR_INIT_COUNTER:   init_ctr_ff     <= csr_bus.data[1:0];
            CSR_GLOBAL_HISTORY: global_hist_ff  <= csr_bus.data[0];
            CSR_GLOBAL_TABLE:   global_table_ff <= csr_bus.data[0];
            CSR_SHARE_MODE:     share_mode_ff   <= csr_bus.data[1:0];
            default: ;
         endcase
      end
   end

   // item payload and lookup results
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_bus.opcode;
         pc_ff      <= req_bus.pc;
         tgt_ff     <= req_bus.actual_target;
         taken_ff   <= req_bus.was_taken;
         earlier_ff <= req_bus.earlier_prediction;
         idx_ff     <= req_idx;
         tag_ff     <= req_tag;
      end
      if (state_ff == ST_LOOKUP) begin
         hit_ff         <= hit;
         alloc_local_ff <= alloc && !global_table_ff;
         pos_ff         <= pos;
         row_ff         <= row;
         ent_target_ff  <= ent_target;
      end
   end

   // predictor state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         row_valid_ff   <= '0;
         shared_hist_ff <= '0;
         flush_cnt_ff   <= '0;
         branch_cnt_ff  <= '0;
      end else begin
         if (state_ff == ST_LOOKUP && op_ff) begin
            valid_ff[idx_ff] <= 1'b1;
            branch_cnt_ff    <= branch_cnt_ff + 32'd1;
            if (mispredict) begin
               flush_cnt_ff <= flush_cnt_ff + 32'd1;
            end
            if (global_hist_ff) begin
               shared_hist_ff <= hist_next;
            end
            if (alloc && global_table_ff) begin
               row_valid_ff[CROW_W'(idx_ff)] <= 1'b1;
            end
         end
         if (state_ff == ST_COUNT && can_finish && op_ff) begin
            row_valid_ff[row_ff] <= 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_COUNT;
         ST_COUNT: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end else if (can_finish) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_COUNT && can_finish) begin
            rsp_valid_ff  <= 1'b1;
            rsp_taken_ff  <= (op_ff == OP_PREDICT) && pred_taken;
            rsp_flush_ff  <= flush_cnt_ff;
            rsp_branch_ff <= branch_cnt_ff;
            if (op_ff == OP_UPDATE) begin
               rsp_target_ff <= '0;
            end else if (pred_taken) begin
               rsp_target_ff <= ent_target_ff;
            end else begin
               rsp_target_ff <= pc_ff + PC_STEP;
            end
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.predict_taken    = rsp_taken_ff;
   assign rsp_bus.predicted_target = rsp_target_ff;
   assign rsp_bus.flush_count      = rsp_flush_ff;
   assign rsp_bus.branch_count     = rsp_branch_ff;

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted item did not enter lookup");

   a_rsp_from_count: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COUNT))
      else $error("response raised outside the count cycle");

   a_branch_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && op_ff) |=> branch_cnt_ff == $past(branch_cnt_ff) + 32'd1)
      else $error("branch count did not advance on update");

   a_branch_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOOKUP) |=> branch_cnt_ff == $past(branch_cnt_ff))
      else $error("branch count moved outside an update");

   a_update_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && op_ff) |=> valid_ff[idx_ff])
      else $error("updated entry not marked valid");

endmodule

// ===== rtl/core/btb2l_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependency.
module btb2l_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the two-level branch predictor BTB core.
// Depends on btb2l_pkg, the btb2l channel interfaces and the core itself; an in-bench
// predictor tracks entries, histories, counter tables and totals to check every result.
module testbench;
   import btb2l_pkg::*;

   localparam int HIST_CAP = 8;
   localparam int ROW_LEN  = 1 << HIST_CAP;
   localparam int BTB_SLOTS = 32;
   localparam int POOL_LEN = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_INDEX = 3'd7;
   localparam logic [1:0]           SHARE_SPARE     = 2'd3;

   typedef struct packed {
      opcode_type      opcode;
      logic [PC_W-1:0] pc;
      logic [PC_W-1:0] actual_target;
      logic            was_taken;
      logic [PC_W-1:0] earlier_prediction;
   } branch_item_t;

   typedef struct packed {
      logic            predict_taken;
      logic [PC_W-1:0] predicted_target;
      logic [PC_W-1:0] flush_count;
      logic [PC_W-1:0] branch_count;
   } branch_outcome_t;

   logic clock = 1'b0;
   logic reset;

   btb2l_req_if req_bus ();
   btb2l_rsp_if rsp_bus ();
   btb2l_csr_if csr_bus ();

   btb_two_level_branch_predictor_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the configuration
   logic [2:0] cfg_log2_entries;
   logic [3:0] cfg_history_bits;
   logic [4:0] cfg_tag_bits;
   logic [1:0] cfg_init_counter;
   logic       cfg_global_history;
   logic       cfg_global_table;
   logic [1:0] cfg_share_mode;

   // predictor copy of the state
   logic             btb_valid    [BTB_SLOTS];
   logic [TAG_W-1:0] btb_tag      [BTB_SLOTS];
   logic [PC_W-1:0]  btb_target   [BTB_SLOTS];
   logic [7:0]       local_hist   [BTB_SLOTS];
   logic [1:0]       local_ctr    [BTB_SLOTS][ROW_LEN];
   logic [7:0]       shared_hist;
   logic [1:0]       shared_ctr   [ROW_LEN];
   logic [PC_W-1:0]  flush_total;
   logic [PC_W-1:0]  branch_total;

   branch_outcome_t pending_outcomes [$];
   int              mismatch_count = 0;

   bit req_gaps_on   = 1'b0;
   bit rsp_gaps_on   = 1'b0;
   int rsp_gap_left  = 0;
   int rsp_hold_left = 0;

   logic [PC_W-1:0] pool_pc     [POOL_LEN];
   logic [PC_W-1:0] pool_target [POOL_LEN];
   int              pool_bias   [POOL_LEN];

   // Work out the result of one item and advance the predictor state.
   function automatic branch_outcome_t resolve_branch(input branch_item_t it);
      int unsigned     le;
      int unsigned     tb;
      int unsigned     hl;
      int              k;
      logic [PC_W-1:0] hmask;
      logic [PC_W-1:0] idx;
      logic [PC_W-1:0] tag;
      logic [PC_W-1:0] hist;
      logic [PC_W-1:0] slot;
      logic [1:0]      ctr;
      logic            hit;
      logic            missed;
      branch_outcome_t res;
      le = (cfg_log2_entries > MAX_LOG2_ENTRIES) ? MAX_LOG2_ENTRIES : cfg_log2_entries;
      tb = (cfg_tag_bits > MAX_TAG_BITS) ? MAX_TAG_BITS : cfg_tag_bits;
      hl = (cfg_history_bits > HIST_CAP) ? HIST_CAP : cfg_history_bits;
      hmask = (32'd1 << hl) - 32'd1;
      idx = (it.pc >> 2) & ((32'd1 << le) - 32'd1);
      tag = (it.pc >> (2 + le)) & ((32'd1 << tb) - 32'd1);
      hit = btb_valid[idx] && (btb_tag[idx] == tag[TAG_W-1:0]);
      if (it.opcode == OP_UPDATE && !hit) begin
         // allocate: fresh history and a refilled local row, sharing flags aside
         btb_valid[idx]  = 1'b1;
         btb_tag[idx]    = tag[TAG_W-1:0];
         local_hist[idx] = 8'd0;
         for (k = 0; k < ROW_LEN; k++) local_ctr[idx][k] = cfg_init_counter;
      end
      hist = cfg_global_history ? {24'd0, shared_hist} : {24'd0, local_hist[idx]};
      case (cfg_share_mode)
         SHARE_XOR_LO: slot = hist ^ (it.pc >> SHARE_LO);
         SHARE_XOR_HI: slot = hist ^ (it.pc >> SHARE_HI);
         default:      slot = hist;
      endcase
      slot = slot & hmask;
      ctr = cfg_global_table ? shared_ctr[slot] : local_ctr[idx][slot];
      res = '0;
      if (it.opcode == OP_PREDICT) begin
         res.predicted_target = it.pc + PC_STEP;
         if (hit && ctr >= CTR_TAKEN_MIN) begin
            res.predict_taken    = 1'b1;
            res.predicted_target = btb_target[idx];
         end
      end else begin
         btb_target[idx] = it.actual_target;
         if (it.was_taken) begin
            if (ctr != CTR_MAX) ctr = ctr + 2'd1;
         end else if (ctr != CTR_MIN) begin
            ctr = ctr - 2'd1;
         end
         if (cfg_global_table) shared_ctr[slot] = ctr;
         else local_ctr[idx][slot] = ctr;
         hist = ((hist << 1) | {31'd0, it.was_taken}) & hmask;
         if (cfg_global_history) shared_hist = hist[7:0];
         else local_hist[idx] = hist[7:0];
         missed = it.was_taken ? (it.earlier_prediction != it.actual_target)
                               : (it.earlier_prediction != it.pc + PC_STEP);
         if (missed) flush_total = flush_total + 32'd1;
         branch_total = branch_total + 32'd1;
      end
      res.flush_count  = flush_total;
      res.branch_count = branch_total;
      return res;
   endfunction

   function automatic void note_mismatch(input string what, input logic [PC_W-1:0] want,
                                         input logic [PC_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endfunction

   // Result side: sample at the rising edge, compare with the oldest expectation.
   always @(posedge clock) begin : check_outcomes
      branch_outcome_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            note_mismatch("unexpected item", 32'd0, rsp_bus.predicted_target);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.predict_taken !== want.predict_taken)
               note_mismatch("predict_taken", {31'd0, want.predict_taken},
                             {31'd0, rsp_bus.predict_taken});
            if (rsp_bus.predicted_target !== want.predicted_target)
               note_mismatch("predicted_target", want.predicted_target,
                             rsp_bus.predicted_target);
            if (rsp_bus.flush_count !== want.flush_count)
               note_mismatch("flush_count", want.flush_count, rsp_bus.flush_count);
            if (rsp_bus.branch_count !== want.branch_count)
               note_mismatch("branch_count", want.branch_count, rsp_bus.branch_count);
         end
         rsp_gap_left = rsp_gaps_on ? $urandom_range(0, 3) : 0;
      end
   end

   // Result ready: long hold-offs first, then the per-item gap.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic send_item(input branch_item_t it);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid              <= 1'b1;
      req_bus.opcode             <= it.opcode;
      req_bus.pc                 <= it.pc;
      req_bus.actual_target      <= it.actual_target;
      req_bus.was_taken          <= it.was_taken;
      req_bus.earlier_prediction <= it.earlier_prediction;
      do @(posedge clock); while (!req_bus.ready);
      pending_outcomes.push_back(resolve_branch(it));
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_LOG2_ENTRIES:   cfg_log2_entries   = data[2:0];
         CSR_HISTORY_BITS:   cfg_history_bits   = data[3:0];
         CSR_TAG_BITS:       cfg_tag_bits       = data[4:0];
         CSR_INIT_COUNTER:   cfg_init_counter   = data[1:0];
         CSR_GLOBAL_HISTORY: cfg_global_history = data[0];
         CSR_GLOBAL_TABLE:   cfg_global_table   = data[0];
         CSR_SHARE_MODE:     cfg_share_mode     = data[1:0];
         default: ;
      endcase
   endtask

   // Write every register; the unused upper data bits carry noise.
   task automatic apply_settings(input logic [2:0] log2e, input logic [3:0] hbits,
                                 input logic [4:0] tbits, input logic [1:0] ictr,
                                 input logic ghist, input logic gtab, input logic [1:0] share);
      logic [CSR_DATA_W-1:0] noise [7];
      foreach (noise[i]) noise[i] = CSR_DATA_W'($urandom);
      write_csr(CSR_LOG2_ENTRIES,   {noise[0][7:3], log2e});
      write_csr(CSR_HISTORY_BITS,   {noise[1][7:4], hbits});
      write_csr(CSR_TAG_BITS,       {noise[2][7:5], tbits});
      write_csr(CSR_INIT_COUNTER,   {noise[3][7:2], ictr});
      write_csr(CSR_GLOBAL_HISTORY, {noise[4][7:1], ghist});
      write_csr(CSR_GLOBAL_TABLE,   {noise[5][7:1], gtab});
      write_csr(CSR_SHARE_MODE,     {noise[6][7:2], share});
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Half the branches alias onto the first one's index, differing from it only above bit 6.
   task automatic draw_branch_pool();
      foreach (pool_pc[k]) begin
         pool_pc[k]     = (k < POOL_LEN / 2) ? $urandom : pool_pc[0] ^ ($urandom << 7);
         pool_target[k] = $urandom;
         pool_bias[k]   = $urandom_range(0, 100);
      end
   endtask

   task automatic send_random_item();
      branch_item_t it;
      int           k;
      int           roll;
      k    = $urandom_range(0, POOL_LEN - 1);
      roll = $urandom_range(0, 99);
      it.opcode             = opcode_type'($urandom_range(0, 1));
      it.pc                 = $urandom;
      it.actual_target      = $urandom;
      it.was_taken          = $urandom_range(0, 1);
      it.earlier_prediction = $urandom;
      if (roll < 85) begin
         // well-formed traffic on the branch pool
         it.pc        = pool_pc[k];
         it.opcode    = (roll < 45) ? OP_UPDATE : OP_PREDICT;
         it.was_taken = $urandom_range(0, 99) < pool_bias[k];
         if ($urandom_range(0, 9) != 0) it.actual_target = pool_target[k];
         case ($urandom_range(0, 9))
            0:          ;
            1, 2, 3, 4: it.earlier_prediction = it.actual_target;
            default:    it.earlier_prediction = it.pc + PC_STEP;
         endcase
      end
      send_item(it);
   endtask

   task automatic test_directed_edges();
      int n;
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      send_item('{OP_PREDICT, 32'h0000_0000, 32'h0, 1'b0, 32'h0});
      send_item('{OP_PREDICT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF});
      send_item('{OP_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0});
      // allocate, then train until the history saturates
      send_item('{OP_UPDATE, 32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_1004});
      for (n = 0; n < 10; n++)
         send_item('{OP_UPDATE, 32'h0000_1000, 32'h0000_2000, 1'b1, 32'h0000_2000});
      send_item('{OP_PREDICT, 32'h0000_1000, 32'h0, 1'b0, 32'h0});
      send_item('{OP_UPDATE, 32'h0000_1000, 32'h0000_2000, 1'b0, 32'h0000_2000});
      send_item('{OP_UPDATE, 32'h0000_1000, 32'h0000_2000, 1'b0, 32'h0000_1004});
      // same index, other tag: evicts the trained entry
      send_item('{OP_UPDATE, 32'h0001_1000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF});
      send_item('{OP_PREDICT, 32'h0000_1000, 32'h0, 1'b0, 32'h0});
      send_item('{OP_PREDICT, 32'h0001_1000, 32'h0, 1'b0, 32'h0});
      // fall-through address wraps past the top of memory
      send_item('{OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 32'h0000_0003});
      send_item('{OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000});
      send_item('{OP_PREDICT, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0});
      wait_drained();
   endtask

   task automatic test_config_sweep();
      int p;
      int n;
      write_csr(CSR_SPARE_INDEX, CSR_DATA_W'($urandom));
      for (p = 0; p < 10; p++) begin
         case (p)
            0: apply_settings(3'd0, 4'd1, 5'd0, 2'd0, 1'b1, 1'b1, SHARE_XOR_LO);
            1: apply_settings(3'd7, 4'd15, 5'd31, 2'd3, 1'b0, 1'b0, SHARE_XOR_HI);
            2: apply_settings(3'd2, 4'd0, 5'd3, 2'd2, 1'b1, 1'b0, SHARE_SPARE);
            3: apply_settings(3'd5, 4'd8, 5'd30, 2'd1, 1'b0, 1'b1, SHARE_XOR_LO);
            4: apply_settings(3'd6, 4'd9, 5'd1, 2'd0, 1'b0, 1'b0, SHARE_NONE);
            default: apply_settings($urandom_range(0, 7), $urandom_range(0, 15),
                                    $urandom_range(0, 31), $urandom_range(0, 3),
                                    $urandom_range(0, 1), $urandom_range(0, 1),
                                    $urandom_range(0, 3));
         endcase
         req_gaps_on = (p % 5 != 4) && (p % 3 != 2);
         rsp_gaps_on = (p % 5 != 4) && (p % 3 != 1);
         draw_branch_pool();
         for (n = 0; n < 190; n++) send_random_item();
         wait_drained();
      end
   endtask

   // Hold the result side off while items keep coming, so the input stalls.
   task automatic test_output_stall();
      draw_branch_pool();
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      @(posedge clock);
      rsp_hold_left = 80;
      repeat (48) send_random_item();
      rsp_gaps_on = 1'b1;
      wait_drained();
   endtask

   initial begin
      #2000000;
      $display("testbench failed");
      $finish;
   end

   initial begin
      reset                      = 1'b1;
      req_bus.valid              = 1'b0;
      req_bus.opcode             = OP_PREDICT;
      req_bus.pc                 = '0;
      req_bus.actual_target      = '0;
      req_bus.was_taken          = 1'b0;
      req_bus.earlier_prediction = '0;
      rsp_bus.ready              = 1'b0;
      csr_bus.valid              = 1'b0;
      csr_bus.index              = CSR_LOG2_ENTRIES;
      csr_bus.data               = '0;

      cfg_log2_entries   = RST_LOG2_ENTRIES;
      cfg_history_bits   = RST_HISTORY_BITS;
      cfg_tag_bits       = RST_TAG_BITS;
      cfg_init_counter   = RST_INIT_CTR;
      cfg_global_history = 1'b0;
      cfg_global_table   = 1'b0;
      cfg_share_mode     = SHARE_NONE;
      foreach (btb_valid[i]) begin
         btb_valid[i]  = 1'b0;
         btb_tag[i]    = '0;
         btb_target[i] = '0;
         local_hist[i] = '0;
      end
      foreach (local_ctr[i, j]) local_ctr[i][j] = RST_INIT_CTR;
      foreach (shared_ctr[j]) shared_ctr[j] = RST_INIT_CTR;
      shared_hist  = '0;
      flush_total  = '0;
      branch_total = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_config_sweep();
      test_output_stall();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/btb2l_pkg.sv
rtl/core/btb2l_if.sv
rtl/core/btb2l_ram.sv
rtl/core/btb_two_level_branch_predictor_core.sv
tb/sv/testbench.sv
